// ===== hw/rtl/ssc_pkg.sv =====
`timescale 1ns / 1ps

package ssc_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_TARGET  = 1023;
   localparam int DEF_COUNT_BITS  = 32;

   // Fixed field widths
   localparam int TARGET_W        = 10;
   localparam int ELEM_W          = 16;
   localparam int OUT_W           = 32;
   // Wide enough to compare any element or target against MAX_TARGET
   localparam int WIDE_W          = 17;

   // Depth of the command queue and of the result queue (power of two)
   localparam int QUEUE_DEPTH     = 2;

   // Classified item handed from the front to the back
   typedef struct packed {
      logic [ELEM_W-1:0] elem;
      logic              skip;   // element above MAX_TARGET, table untouched
      logic              last;
   } cmd_type;

   // One result item
   typedef struct packed {
      logic [OUT_W-1:0] count;
      logic             sat;
      logic             done;
   } rsp_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_READ,
      ST_REPLY
   } state_type;

endpackage

// ===== hw/rtl/ssc_fifo.sv =====
`timescale 1ns / 1ps

module ssc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ssc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);

   logic [PW:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW:0]      rd_ptr_ff, rd_ptr_in;
   logic [WIDTH-1:0] data_ff [DEPTH];
   logic             do_push;
   logic             do_pop;

   // Status from pointer compare; extra bit tells full from empty
   assign full  = (wr_ptr_ff[PW] != rd_ptr_ff[PW]) &&
                  (wr_ptr_ff[PW-1:0] == rd_ptr_ff[PW-1:0]);
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign rdata = data_ff[rd_ptr_ff[PW-1:0]];

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer advance
   always_comb begin
      wr_ptr_in = wr_ptr_ff + {{PW{1'b0}}, do_push};
      rd_ptr_in = rd_ptr_ff + {{PW{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff[PW-1:0]] <= wdata;
      end
   end

endmodule

// ===== hw/rtl/ssc_front.sv =====
`timescale 1ns / 1ps

module ssc_front #(
   parameter int MAX_TARGET = ssc_pkg::DEF_MAX_TARGET
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [ssc_pkg::ELEM_W-1:0] req_element_value,
   input  logic                      req_last_element,
   input  logic                      hold,
   output logic                      req_full,
   input  logic                      cmd_pop,
   output logic                      cmd_empty,
   output ssc_pkg::cmd_type          cmd
);

   ssc_pkg::cmd_type cmd_wr;
   logic             queue_full;

   // Classify: elements above the table range leave it unchanged
   always_comb begin
      cmd_wr.elem = req_element_value;
      cmd_wr.skip = (ssc_pkg::WIDE_W'(req_element_value) >
                     ssc_pkg::WIDE_W'(MAX_TARGET));
      cmd_wr.last = req_last_element;
   end

   // No transfer while the back end clears the table
   assign req_full = queue_full || hold;

   ssc_fifo #(
      .WIDTH ($bits(ssc_pkg::cmd_type)),
      .DEPTH (ssc_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push && !req_full),
      .wdata (cmd_wr),
      .full  (queue_full),
      .pop   (cmd_pop),
      .rdata (cmd),
      .empty (cmd_empty)
   );

endmodule

// ===== hw/rtl/ssc_back.sv =====
`timescale 1ns / 1ps

module ssc_back #(
   parameter int MAX_TARGET = ssc_pkg::DEF_MAX_TARGET,
   parameter int COUNT_BITS = ssc_pkg::DEF_COUNT_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [ssc_pkg::TARGET_W-1:0] csr_target_sum,
   input  logic                        cmd_empty,
   input  ssc_pkg::cmd_type            cmd,
   output logic                        cmd_pop,
   input  logic                        rsp_full,
   output logic                        rsp_push,
   output ssc_pkg::rsp_type            rsp,
   output logic                        clear_busy
);

   localparam int TABLE_LEN = MAX_TARGET + 1;
   localparam int AW        = $clog2(TABLE_LEN);
   localparam logic [AW-1:0]         TOP_ADDR  = AW'(MAX_TARGET);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] OUT_CLAMP = COUNT_BITS'(32'hFFFF_FFFF);

   ssc_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                s_ff, s_in;           // sweep address
   logic [AW-1:0]                elem_ff, elem_in;
   logic                         last_ff, last_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic                         ovf_ff, ovf_in;
   logic [ssc_pkg::TARGET_W-1:0] target_ff, target_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic [AW-1:0]                wr_addr_ff, wr_addr_in;
   logic [COUNT_BITS-1:0]        rdata_a_ff;
   logic [COUNT_BITS-1:0]        rdata_b_ff;
   logic [COUNT_BITS-1:0]        table_mem [TABLE_LEN];

   logic                         issue;
   logic [AW-1:0]                rd_addr_a;
   logic [AW-1:0]                rd_addr_b;
   logic [AW-1:0]                tgt_addr;
   logic                         tgt_ok;
   logic [COUNT_BITS:0]          sum_wide;
   logic                         sat;
   logic [COUNT_BITS-1:0]        upd_val;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [COUNT_BITS-1:0]        wr_data;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssc_pkg::ST_CLEAR: begin
            if (clr_ff == TOP_ADDR) state_in = ssc_pkg::ST_IDLE;
         end
         ssc_pkg::ST_IDLE: begin
            if (!cmd_empty) state_in = cmd.skip ? ssc_pkg::ST_READ : ssc_pkg::ST_SWEEP;
         end
         ssc_pkg::ST_SWEEP: begin
            if (s_ff == elem_ff) state_in = ssc_pkg::ST_DRAIN;
         end
         ssc_pkg::ST_DRAIN: state_in = ssc_pkg::ST_READ;
         ssc_pkg::ST_READ:  state_in = ssc_pkg::ST_REPLY;
         ssc_pkg::ST_REPLY: begin
            if (!rsp_full) state_in = last_ff ? ssc_pkg::ST_CLEAR : ssc_pkg::ST_IDLE;
         end
         default: state_in = ssc_pkg::ST_CLEAR;
      endcase
   end

   // State-decoded controls
   always_comb begin
      cmd_pop    = (state_ff == ssc_pkg::ST_IDLE) && !cmd_empty;
      rsp_push   = (state_ff == ssc_pkg::ST_REPLY) && !rsp_full;
      clear_busy = (state_ff == ssc_pkg::ST_CLEAR);
      issue      = (state_ff == ssc_pkg::ST_SWEEP);
   end

   // Target lookup; targets past the table report zero
   assign tgt_ok   = (ssc_pkg::WIDE_W'(target_ff) <= ssc_pkg::WIDE_W'(MAX_TARGET));
   assign tgt_addr = AW'(target_ff);

   // Read ports: entry s (the target outside the sweep) and entry s minus element
   assign rd_addr_a = issue ? s_ff : tgt_addr;
   assign rd_addr_b = s_ff - elem_ff;

   // Saturating add on registered read data
   always_comb begin
      sum_wide = {1'b0, rdata_a_ff} + {1'b0, rdata_b_ff};
      sat      = sum_wide[COUNT_BITS];
      upd_val  = sat ? {COUNT_BITS{1'b1}} : sum_wide[COUNT_BITS-1:0];
   end

   // Write port: sweep update or clearing pass
   always_comb begin
      wr_en   = wr_pend_ff || clear_busy;
      wr_addr = wr_pend_ff ? wr_addr_ff : clr_ff;
      if (wr_pend_ff) begin
         wr_data = upd_val;
      end else begin
         wr_data = (clr_ff == '0) ? COUNT_ONE : '0;
      end
   end

   // Datapath next values
   always_comb begin
      s_in       = s_ff;
      elem_in    = elem_ff;
      last_in    = last_ff;
      clr_in     = clr_ff;
      ovf_in     = ovf_ff;
      target_in  = target_ff;
      wr_pend_in = issue;
      wr_addr_in = s_ff;

      if (cmd_pop) begin
         elem_in = cmd.elem[AW-1:0];
         last_in = cmd.last;
         s_in    = TOP_ADDR;
      end
      if (issue && (s_ff != elem_ff)) s_in = s_ff - 1'b1;

      if (wr_pend_ff && sat) ovf_in = 1'b1;

      if (clear_busy) clr_in = (clr_ff == TOP_ADDR) ? '0 : clr_ff + 1'b1;

      // End of set: flag drops once the result is out
      if (rsp_push && last_ff) begin
         ovf_in = 1'b0;
         clr_in = '0;
      end

      if (csr_write_enable) target_in = csr_target_sum;
   end

   // Result item
   always_comb begin
      if (!tgt_ok) begin
         rsp.count = '0;
      end else if (rdata_a_ff > OUT_CLAMP) begin
         rsp.count = {ssc_pkg::OUT_W{1'b1}};
      end else begin
         rsp.count = ssc_pkg::OUT_W'(rdata_a_ff);
      end
      rsp.sat  = ovf_ff;
      rsp.done = last_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ssc_pkg::ST_CLEAR;
         clr_ff     <= '0;
         ovf_ff     <= 1'b0;
         target_ff  <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         ovf_ff     <= ovf_in;
         target_ff  <= target_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s_ff       <= s_in;
      elem_ff    <= elem_in;
      last_ff    <= last_in;
      wr_addr_ff <= wr_addr_in;
   end

   // Count table: one write, two registered reads per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rdata_a_ff <= table_mem[rd_addr_a];
      rdata_b_ff <= table_mem[rd_addr_b];
   end

   // Sweep never passes below the element
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssc_pkg::ST_SWEEP) |-> (s_ff >= elem_ff))
      else $error("sweep address below element");

   // Last sweep write lands in the drain cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssc_pkg::ST_DRAIN) |-> wr_pend_ff)
      else $error("drain without pending write");

   // Table quiet while waiting or reading the target
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssc_pkg::ST_IDLE || state_ff == ssc_pkg::ST_READ) |-> !wr_en)
      else $error("table write outside sweep or clear");

   // Sticky flag is clear for the whole clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssc_pkg::ST_CLEAR) |-> !ovf_ff)
      else $error("saturation flag set during clear");

   // A taken command starts a sweep or a direct read
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == ssc_pkg::ST_SWEEP || state_ff == ssc_pkg::ST_READ))
      else $error("command taken without starting work");

endmodule

// ===== hw/rtl/subset_sum_count.sv =====
`timescale 1ns / 1ps

// Streaming count of the subsets of a set that reach target_sum.
// Input channel (req_): push one element per transfer while req_full is low;
// req_last_element marks the final element of a set. Result channel (rsp_):
// one result per element, oldest on the ports while rsp_empty is low, taken
// with rsp_pop. Each result carries the count for the target after that
// element, the sticky saturation flag of the set and the last flag echoed.
// csr_write_enable/csr_target_sum set the target; write it only while idle.
// Operation: an element v up to MAX_TARGET sweeps the table from MAX_TARGET
// down to v, one entry per cycle over one write and two read ports; an
// element above MAX_TARGET skips the sweep and only reads the target. After a
// last element the table is cleared before the next element starts. Reset
// clears all control state and starts the same clearing pass; req_full stays
// high during any clearing pass. A two-entry command queue and a two-entry
// result queue decouple the sides: when the receiver stops popping, the back
// end holds its result and the input fills and stalls.
module subset_sum_count #(
   parameter int MAX_TARGET = ssc_pkg::DEF_MAX_TARGET,
   parameter int COUNT_BITS = ssc_pkg::DEF_COUNT_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [ssc_pkg::ELEM_W-1:0]   req_element_value,
   input  logic                        req_last_element,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [ssc_pkg::OUT_W-1:0]    rsp_subset_count,
   output logic                        rsp_count_saturated,
   output logic                        rsp_set_done,
   input  logic                        csr_write_enable,
   input  logic [ssc_pkg::TARGET_W-1:0] csr_target_sum
);

   ssc_pkg::cmd_type cmd;
   logic             cmd_empty;
   logic             cmd_pop;
   ssc_pkg::rsp_type rsp_wr;
   ssc_pkg::rsp_type rsp_rd;
   logic             rsp_push;
   logic             rsp_full;
   logic             clear_busy;

   // Front: accept and classify elements
   ssc_front #(
      .MAX_TARGET (MAX_TARGET)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_element_value (req_element_value),
      .req_last_element  (req_last_element),
      .hold              (clear_busy),
      .req_full          (req_full),
      .cmd_pop           (cmd_pop),
      .cmd_empty         (cmd_empty),
      .cmd               (cmd)
   );

   // Back: table sweep, target lookup, clearing
   ssc_back #(
      .MAX_TARGET (MAX_TARGET),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_target_sum   (csr_target_sum),
      .cmd_empty        (cmd_empty),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_full         (rsp_full),
      .rsp_push         (rsp_push),
      .rsp              (rsp_wr),
      .clear_busy       (clear_busy)
   );

   // Result queue
   ssc_fifo #(
      .WIDTH ($bits(ssc_pkg::rsp_type)),
      .DEPTH (ssc_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rd),
      .empty (rsp_empty)
   );

   assign rsp_subset_count    = rsp_rd.count;
   assign rsp_count_saturated = rsp_rd.sat;
   assign rsp_set_done        = rsp_rd.done;

endmodule

// ===== tb/subset_sum_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of subset_sum_count, keeps its own subset-count table
// and compares every result transfer with the oldest predicted result.
module subset_sum_checker #(
   parameter int MAX_TARGET = ssc_pkg::DEF_MAX_TARGET,
   parameter int COUNT_BITS = ssc_pkg::DEF_COUNT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic                         req_full,
   input  logic [ssc_pkg::ELEM_W-1:0]   req_element_value,
   input  logic                         req_last_element,
   input  logic                         rsp_empty,
   input  logic                         rsp_pop,
   input  logic [ssc_pkg::OUT_W-1:0]    rsp_subset_count,
   input  logic                         rsp_count_saturated,
   input  logic                         rsp_set_done,
   input  logic                         csr_write_enable,
   input  logic [ssc_pkg::TARGET_W-1:0] csr_target_sum,
   output int                           mismatches,
   output int                           outstanding
);

   localparam longint unsigned COUNT_CAP = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);

   // Shadow of the block: subsets per sum, sticky saturation, target register
   longint unsigned              sum_counts [0:MAX_TARGET];
   logic                         sat_seen;
   logic [ssc_pkg::TARGET_W-1:0] target;
   ssc_pkg::rsp_type             due_results [$];
   int                           error_total = 0;

   // Back to the empty-subset state
   function automatic void clear_counts();
      for (int s = 0; s <= MAX_TARGET; s++) sum_counts[s] = 0;
      sum_counts[0] = 1;
      sat_seen = 1'b0;
   endfunction

   function automatic longint unsigned clamp_add(longint unsigned a, longint unsigned b);
      if (a > COUNT_CAP) a = COUNT_CAP;
      if (b > COUNT_CAP) b = COUNT_CAP;
      if (b > COUNT_CAP - a) begin
         sat_seen = 1'b1;
         return COUNT_CAP;
      end
      return a + b;
   endfunction

   // Fold one element into the table and form the result it produces
   function automatic ssc_pkg::rsp_type count_after_element(
      logic [ssc_pkg::ELEM_W-1:0] value, logic last);
      ssc_pkg::rsp_type r;
      longint unsigned  c;
      int               vi;
      vi = int'(value);
      // downward sweep so each element is used at most once per subset
      if (vi <= MAX_TARGET) begin
         for (int s = MAX_TARGET; s >= vi; s--)
            sum_counts[s] = clamp_add(sum_counts[s], sum_counts[s - vi]);
      end
      c = (int'(target) <= MAX_TARGET) ? sum_counts[target] : 0;
      if (c > 64'h0000_0000_FFFF_FFFF) c = 64'h0000_0000_FFFF_FFFF;
      r.count = c[ssc_pkg::OUT_W-1:0];
      r.sat   = sat_seen;
      r.done  = last;
      if (last) clear_counts();
      return r;
   endfunction

   // Track transfers on every channel, compare results in order
   always @(posedge clock) begin
      ssc_pkg::rsp_type want;
      ssc_pkg::rsp_type seen;
      if (reset) begin
         due_results.delete();
         clear_counts();
         target = '0;
      end else begin
         if (csr_write_enable) target = csr_target_sum;
         if (req_push && !req_full)
            due_results.push_back(count_after_element(req_element_value, req_last_element));
         if (rsp_pop && !rsp_empty) begin
            seen = '{count: rsp_subset_count, sat: rsp_count_saturated, done: rsp_set_done};
            if (due_results.size() == 0) begin
               $error("result transfer with nothing expected: subset_count %0d", seen.count);
               error_total++;
            end else begin
               want = due_results.pop_front();
               if (seen.count !== want.count) begin
                  $error("subset_count: expected %0d, got %0d", want.count, seen.count);
                  error_total++;
               end
               if (seen.sat !== want.sat) begin
                  $error("count_saturated: expected %0b, got %0b", want.sat, seen.sat);
                  error_total++;
               end
               if (seen.done !== want.done) begin
                  $error("set_done: expected %0b, got %0b", want.done, seen.done);
                  error_total++;
               end
            end
         end
      end
      outstanding <= due_results.size();
      mismatches  <= error_total;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int     MAX_T       = ssc_pkg::DEF_MAX_TARGET;
   localparam longint CYCLE_LIMIT = 30_000_000;
   localparam int     PHASES      = 8;
   localparam int     PHASE_ITEMS = 72;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_push = 1'b0;
   logic                         req_full;
   logic [ssc_pkg::ELEM_W-1:0]   req_element_value = '0;
   logic                         req_last_element = 1'b0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic [ssc_pkg::OUT_W-1:0]    rsp_subset_count;
   logic                         rsp_count_saturated;
   logic                         rsp_set_done;
   logic                         csr_write_enable = 1'b0;
   logic [ssc_pkg::TARGET_W-1:0] csr_target_sum = '0;

   int     mismatches;
   int     outstanding;
   longint cycle_count = 0;
   int     pop_hold = 0;
   bit     tx_steady = 1'b0;
   bit     rx_steady = 1'b0;
   int     set_left = 0;
   bit     dense_set = 1'b0;
   bit     force_dense = 1'b1;
   int     target_now = 0;

   always #10 clock = ~clock;

   subset_sum_count u_top (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_element_value   (req_element_value),
      .req_last_element    (req_last_element),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_subset_count    (rsp_subset_count),
      .rsp_count_saturated (rsp_count_saturated),
      .rsp_set_done        (rsp_set_done),
      .csr_write_enable    (csr_write_enable),
      .csr_target_sum      (csr_target_sum)
   );

   subset_sum_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_element_value   (req_element_value),
      .req_last_element    (req_last_element),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_subset_count    (rsp_subset_count),
      .rsp_count_saturated (rsp_count_saturated),
      .rsp_set_done        (rsp_set_done),
      .csr_write_enable    (csr_write_enable),
      .csr_target_sum      (csr_target_sum),
      .mismatches          (mismatches),
      .outstanding         (outstanding)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int sender_gap();
      int r;
      if (tx_steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 1500);
   endfunction

   // Rare long stalls let both internal queues fill up
   function automatic int receiver_gap();
      int r;
      if (rx_steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(10, 60);
      return $urandom_range(500, 4000);
   endfunction

   // Result side: pop with random stalls after each transfer
   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= (pop_hold == 1);
      end else if (rsp_pop && !rsp_empty) begin
         g = receiver_gap();
         pop_hold <= g;
         rsp_pop  <= (g == 0);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // One element transfer; push stays high afterwards for back-to-back items
   task automatic push_element(input int value, input logic last);
      int g;
      g = sender_gap();
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_push          <= 1'b1;
      req_element_value <= value[ssc_pkg::ELEM_W-1:0];
      req_last_element  <= last;
      do @(posedge clock); while (req_full);
   endtask

   // Stop sending and let every predicted result come back
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_target(input int t);
      csr_write_enable <= 1'b1;
      csr_target_sum   <= t[ssc_pkg::TARGET_W-1:0];
      target_now = t;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic int pick_element(input int t);
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return 0;
      if (r < 14) return 65535;
      if (r < 22) return $urandom_range(MAX_T + 1, 65535);
      if (r < 32) return t;
      if (r < 88) return $urandom_range(1, (t >> 2) + 3);
      return $urandom_range(0, MAX_T);
   endfunction

   // Next item of the running set; zero-heavy sets drive counts into saturation
   task automatic push_random_item();
      int r;
      int value;
      if (set_left == 0) begin
         r = $urandom_range(0, 99);
         dense_set = force_dense || (r < 12);
         if (dense_set) set_left = $urandom_range(32, 40);
         else if (r < 20) set_left = 1;
         else set_left = $urandom_range(2, 12);
         force_dense = 1'b0;
      end
      if (dense_set && $urandom_range(0, 99) < 85) value = 0;
      else value = pick_element(target_now);
      push_element(value, set_left == 1);
      set_left--;
   endtask

   initial begin
      int t;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: small target, zero, elements above and at the table edge
      write_target(3);
      push_element(1, 1'b0);
      push_element(2, 1'b0);
      push_element(3, 1'b0);
      push_element(0, 1'b0);
      push_element('hFFFF, 1'b0);
      push_element(MAX_T + 1, 1'b0);
      push_element(MAX_T, 1'b1);
      // fresh table after the end of a set
      push_element(3, 1'b1);
      wait_idle();
      write_target(0);
      push_element(0, 1'b0);
      push_element(0, 1'b0);
      push_element(7, 1'b1);
      wait_idle();
      write_target(MAX_T);
      push_element(MAX_T, 1'b0);
      push_element(1000, 1'b0);
      push_element(23, 1'b0);
      push_element(0, 1'b1);
      push_element(MAX_T, 1'b0);
      push_element(512, 1'b0);
      // target moved in the middle of a set
      wait_idle();
      write_target(511);
      push_element(511, 1'b1);
      wait_idle();

      // Random phases, each with its own target and idling style
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: t = 0;
            1: t = MAX_T;
            2: t = $urandom_range(1, 15);
            3: t = MAX_T - 1;
            default: t = $urandom_range(0, 1) ? $urandom_range(1, 63) : $urandom_range(0, MAX_T);
         endcase
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         write_target(t);
         for (int i = 0; i < PHASE_ITEMS; i++) push_random_item();
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
